// ----- design/swm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding window minimum package
// Shared widths, default sizes and the command/status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int WINDOW_MAX_DEF  = 64;
  localparam int VALUE_WIDTH_DEF = 16;

  // Window length register and sample position counter widths.
  localparam int CFG_W = 7;
  localparam int POS_W = 16;

  typedef struct packed {
    logic load;        // a request is accepted this cycle
    logic eval_first;  // first evaluation cycle of the current sample
    logic eval;        // evaluation cycle: head age check and tail pops
    logic push;        // sample is written and the result is registered
  } swm_cmd_t;

  typedef struct packed {
    logic tail_pop;    // the tail entry is popped this cycle
  } swm_sts_t;

endpackage : swm_pkg
`default_nettype wire

// ----- design/swm_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sample channel
// Carries one sample value and its start of sequence flag per request.
// ----------------------------------------------------------------------------
interface swm_in_if import swm_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] sample_value;
  logic                   start_of_sequence;

  modport source (output valid, output sample_value, output start_of_sequence, input ready);
  modport sink   (input valid, input sample_value, input start_of_sequence, output ready);
endinterface : swm_in_if
`default_nettype wire

// ----- design/swm_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Carries the running window minimum, one request per sample.
// ----------------------------------------------------------------------------
interface swm_out_if import swm_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] window_min;

  modport source (output valid, output window_min, input ready);
  modport sink   (input valid, input window_min, output ready);
endinterface : swm_out_if
`default_nettype wire

// ----- design/swm_cfg_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries the window length register write data.
// ----------------------------------------------------------------------------
interface swm_cfg_if import swm_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface : swm_cfg_if
`default_nettype wire

// ----- design/swm_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding window minimum datapath
// Ring-buffer deque of (value, position) pairs with head/tail pointers,
// entry count, position counter, window length register and result register.
// ----------------------------------------------------------------------------
module swm_datapath import swm_pkg::*; #(
  parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic [VALUE_WIDTH-1:0] in_sample,
  input  logic                   in_sos,
  input  swm_cmd_t               cmd,
  output swm_sts_t               sts,
  output logic [VALUE_WIDTH-1:0] out_data
);

  localparam int PTR_W = $clog2(WINDOW_MAX);
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(WINDOW_MAX - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW_MAX);
  localparam logic [POS_W-1:0] LEN_MAX  = POS_W'(WINDOW_MAX);

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] idx);
    return (idx == LAST_IDX) ? '0 : idx + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] idx);
    return (idx == '0) ? LAST_IDX : idx - PTR_W'(1);
  endfunction

  logic [CFG_W-1:0]       window_len_r;
  logic [VALUE_WIDTH-1:0] sample_r;
  logic [POS_W-1:0]       pos_r;
  logic [POS_W-1:0]       pos_cnt_r, pos_cnt_nxt;
  logic [PTR_W-1:0]       head_r, head_nxt;
  logic [PTR_W-1:0]       tail_r, tail_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [VALUE_WIDTH-1:0] out_data_r;

  logic [VALUE_WIDTH-1:0] val_mem [WINDOW_MAX];
  logic [POS_W-1:0]       pos_mem [WINDOW_MAX];
  logic [VALUE_WIDTH-1:0] head_val_r;
  logic [POS_W-1:0]       head_pos_r;
  logic [VALUE_WIDTH-1:0] tail_val_r;

  logic [POS_W-1:0] eff_len;
  logic [POS_W-1:0] age;
  logic             age_pop;
  logic             tail_pop;
  logic             full_pop;
  logic [CNT_W-1:0] cnt_after;
  logic [PTR_W-1:0] rd_head_addr;
  logic [PTR_W-1:0] rd_tail_addr;

  always_comb begin
    if (window_len_r == '0) begin
      eff_len = POS_W'(1);
    end else if (POS_W'(window_len_r) > LEN_MAX) begin
      eff_len = LEN_MAX;
    end else begin
      eff_len = POS_W'(window_len_r);
    end

    // Age is the modular distance from the head entry to the new position.
    age       = pos_r - head_pos_r;
    age_pop   = cmd.eval_first && (count_r != '0) && (age >= eff_len);
    cnt_after = count_r - CNT_W'(age_pop);
    tail_pop  = cmd.eval && (cnt_after != '0) && (tail_val_r > sample_r);
    // A full deque can only follow a window shrink; the head makes room.
    full_pop  = cmd.eval && !tail_pop && (cnt_after == FULL_CNT);

    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    pos_cnt_nxt = pos_cnt_r;
    if (age_pop || full_pop) begin
      head_nxt = ring_next(head_r);
    end
    if (tail_pop) begin
      tail_nxt = ring_prev(tail_r);
    end
    if (cmd.eval) begin
      count_nxt = cnt_after - CNT_W'(tail_pop) - CNT_W'(full_pop);
    end
    if (cmd.push) begin
      tail_nxt  = ring_next(tail_r);
      count_nxt = count_r + CNT_W'(1);
    end
    if (cmd.load) begin
      pos_cnt_nxt = (in_sos ? '0 : pos_cnt_r) + POS_W'(1);
      if (in_sos) begin
        head_nxt  = '0;
        tail_nxt  = '0;
        count_nxt = '0;
      end
    end

    // Read addresses follow the next pointers, so read data matches the
    // pointer registers in the following cycle.
    rd_head_addr = head_nxt;
    rd_tail_addr = ring_prev(tail_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= CFG_W'(1);
      pos_cnt_r    <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
    end else begin
      if (cfg_wr) begin
        window_len_r <= cfg_data;
      end
      pos_cnt_r <= pos_cnt_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= in_sample;
      pos_r    <= in_sos ? '0 : pos_cnt_r;
    end
    if (cmd.push) begin
      out_data_r <= (count_r == '0) ? sample_r : head_val_r;
    end
  end

  // Deque storage with write-through on a same-cycle address match.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      val_mem[tail_r] <= sample_r;
      pos_mem[tail_r] <= pos_r;
    end
    if (cmd.push && (tail_r == rd_head_addr)) begin
      head_val_r <= sample_r;
      head_pos_r <= pos_r;
    end else begin
      head_val_r <= val_mem[rd_head_addr];
      head_pos_r <= pos_mem[rd_head_addr];
    end
    if (cmd.push && (tail_r == rd_tail_addr)) begin
      tail_val_r <= sample_r;
    end else begin
      tail_val_r <= val_mem[rd_tail_addr];
    end
  end

  assign sts.tail_pop = tail_pop;
  assign out_data     = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("deque entry count exceeds capacity");

  a_ring_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    ((count_r == '0) || (count_r == FULL_CNT)) == (head_r == tail_r))
    else $error("deque pointers disagree with entry count");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (count_r != FULL_CNT))
    else $error("push into a full deque");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push && (count_r == '0)) |=> (out_data_r == $past(sample_r)))
    else $error("result of an empty deque is not the new sample");

endmodule : swm_datapath
`default_nettype wire

// ----- design/swm_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding window minimum controller
// Sequences accept, evaluation (head age check and tail pops) and push,
// and owns the result valid flag.
// ----------------------------------------------------------------------------
module swm_ctrl import swm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  swm_sts_t sts,
  output swm_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_PUSH = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       first_r, first_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       load;
  logic       push;

  always_comb begin
    out_free = !out_valid_r || out_ready;
    push     = (state_r == S_PUSH) && out_free;
    // The next request is taken in the same cycle as the current push.
    in_ready = (state_r == S_IDLE) || push;
    load     = in_valid && in_ready;

    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (load) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!sts.tail_pop) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (push) begin
          state_nxt = load ? S_EVAL : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    first_nxt = load ? 1'b1 : ((state_r == S_EVAL) ? 1'b0 : first_r);

    out_valid_nxt = out_valid_r;
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    cmd.load       = load;
    cmd.eval       = (state_r == S_EVAL);
    cmd.eval_first = (state_r == S_EVAL) && first_r;
    cmd.push       = push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule : swm_ctrl
`default_nettype wire

// ----- design/sliding_window_minimum.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding window minimum
// Running minimum over the last window_len samples using a monotonic deque.
// ----------------------------------------------------------------------------
// Timing: after a request is accepted, the evaluation state pops tail entries
// one at a time, and the result is registered in the push state, which waits
// while a held result is not taken. The next request is accepted in the same
// cycle as the current push. Each sample is popped at most once.
// Reset: rst_n (synchronous, active low) empties the deque, clears the
// position counter and sets window_len to 1; the deque memory is not cleared.
module sliding_window_minimum import swm_pkg::*; #(
  parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  swm_in_if.sink    in_chan,
  swm_out_if.source out_chan,
  swm_cfg_if.sink   cfg_chan
);

  swm_cmd_t cmd;
  swm_sts_t sts;
  logic     in_ready;
  logic     out_valid;
  logic [VALUE_WIDTH-1:0] out_data;

  swm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  swm_datapath #(
    .WINDOW_MAX  (WINDOW_MAX),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_chan.valid),
    .cfg_data  (cfg_chan.data),
    .in_sample (in_chan.sample_value),
    .in_sos    (in_chan.start_of_sequence),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

  assign in_chan.ready       = in_ready;
  assign out_chan.valid      = out_valid;
  assign out_chan.window_min = out_data;
  assign cfg_chan.ready      = 1'b1;

endmodule : sliding_window_minimum
`default_nettype wire

// ----- sim/tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding window minimum testbench
// Streams sample requests through the block under several window lengths
// and handshake pressures. A local monotonic deque predicts every window
// minimum, and each result request is checked in order against it.
// ----------------------------------------------------------------------------
module tb import swm_pkg::*;;

  localparam int VW    = VALUE_WIDTH_DEF;
  localparam int DEPTH = WINDOW_MAX_DEF;

  typedef struct packed {
    logic [VW-1:0] value;
    logic          start;
  } sample_t;

  typedef enum int {BURST_RANDOM, BURST_RISING, BURST_FALLING, BURST_CLUSTER} burst_t;

  logic clk = 1'b0;
  logic rst_n;

  swm_in_if  in_if ();
  swm_out_if out_if ();
  swm_cfg_if cfg_if ();

  sliding_window_minimum u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sample_t       pending_samples[$];
  logic [VW-1:0] expected_mins[$];
  int            mismatches     = 0;
  int            send_idle_pct  = 0;
  int            recv_stall_pct = 0;
  int            stall_left     = 0;
  int            stall_arms     = 0;
  int            stall_seen     = 0;

  // Local copy of the candidate deque and the window length register.
  logic [VW-1:0]    cand_value[DEPTH];
  logic [POS_W-1:0] cand_pos[DEPTH];
  int               cand_head  = 0;
  int               cand_tail  = 0;
  int               cand_count = 0;
  logic [POS_W-1:0] next_pos   = '0;
  logic [CFG_W-1:0] window_len_reg = CFG_W'(1);

  function automatic void drop_oldest();
    cand_head = (cand_head == DEPTH - 1) ? 0 : cand_head + 1;
    cand_count--;
  endfunction

  function automatic logic [VW-1:0] next_window_min(sample_t s);
    int               span;
    int               last;
    logic [POS_W-1:0] age;
    if (window_len_reg == 0) span = 1;
    else if (window_len_reg > DEPTH) span = DEPTH;
    else span = int'(window_len_reg);
    if (s.start) begin
      cand_head  = 0;
      cand_tail  = 0;
      cand_count = 0;
      next_pos   = '0;
    end
    // At most one expired head leaves per sample, even after a shrink.
    if (cand_count > 0) begin
      age = next_pos - cand_pos[cand_head];
      if (int'(age) >= span) drop_oldest();
    end
    while (cand_count > 0) begin
      last = (cand_tail == 0) ? DEPTH - 1 : cand_tail - 1;
      if (cand_value[last] > s.value) begin
        cand_tail = last;
        cand_count--;
      end else begin
        break;
      end
    end
    if (cand_count >= DEPTH) drop_oldest();
    cand_value[cand_tail] = s.value;
    cand_pos[cand_tail]   = next_pos;
    cand_tail  = (cand_tail == DEPTH - 1) ? 0 : cand_tail + 1;
    cand_count++;
    next_pos = next_pos + 1'b1;
    return cand_value[cand_head];
  endfunction

  // Sample driver: the request at the head of the queue is offered until taken.
  always @(posedge clk) begin : drive_samples
    logic    offer;
    sample_t taken;
    if (!rst_n) begin
      in_if.valid             <= 1'b0;
      in_if.sample_value      <= '0;
      in_if.start_of_sequence <= 1'b0;
    end else begin
      offer = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        taken = pending_samples[0];
        pending_samples.delete(0);
        expected_mins = {expected_mins, next_window_min(taken)};
        offer = 1'b0;
      end
      if (!offer && pending_samples.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        offer = 1'b1;
        in_if.sample_value      <= pending_samples[0].value;
        in_if.start_of_sequence <= pending_samples[0].start;
      end
      in_if.valid <= offer;
    end
  end

  always @(posedge clk) begin : check_results
    logic [VW-1:0] want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_mins.size() == 0) begin
          $error("window_min: no request outstanding, actual %0d", out_if.window_min);
          mismatches++;
        end else begin
          want = expected_mins[0];
          expected_mins.delete(0);
          if (out_if.window_min !== want) begin
            $error("window_min: expected %0d, actual %0d", want, out_if.window_min);
            mismatches++;
          end
        end
      end
      out_if.ready <= (stall_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off, counted down here once the stimulus arms it.
  always @(posedge clk) begin
    if (stall_arms != stall_seen) begin
      stall_seen <= stall_arms;
      stall_left <= 300;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  task automatic push_sample(int v, bit s);
    sample_t smp;
    smp.value = VW'(v);
    smp.start = s;
    pending_samples = {pending_samples, smp};
  endtask

  task automatic queue_samples(int n, int start_pct);
    burst_t  kind;
    int      run;
    int      v;
    int      step;
    int      d;
    int      base;
    sample_t smp;
    while (n > 0) begin
      kind = burst_t'($urandom_range(3));
      run  = $urandom_range(1, 70);
      if (run > n) run = n;
      v    = $urandom_range(0, 65535);
      base = $urandom_range(0, 65532);
      step = $urandom_range(1, 300);
      repeat (run) begin
        case (kind)
          BURST_RANDOM: begin
            v = $urandom_range(0, 65535);
          end
          BURST_RISING: begin
            d = $urandom_range(0, step);
            v = v + d;
            if (v > 65535) v = 65535;
          end
          BURST_FALLING: begin
            d = $urandom_range(0, step);
            v = v - d;
            if (v < 0) v = 0;
          end
          default: begin
            d = $urandom_range(0, 3);
            v = base + d;
          end
        endcase
        smp.value = VW'(v);
        smp.start = ($urandom_range(99) < start_pct);
        pending_samples = {pending_samples, smp};
        n--;
      end
    end
  endtask

  // Waits until every request has been taken and every result has come back.
  task automatic settle();
    while (pending_samples.size() != 0 || in_if.valid || expected_mins.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_window(logic [CFG_W-1:0] len);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= len;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid   <= 1'b0;
    window_len_reg = len;
    @(negedge clk);
  endtask

  task automatic run_phase(int len, int send_pct, int recv_pct, int n, int start_pct);
    settle();
    write_window(CFG_W'(len));
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    queue_samples(n, start_pct);
  endtask

  initial begin
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    rst_n        = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Window length straight out of reset.
    push_sample(100, 1'b1);
    push_sample(16'hFFFF, 1'b0);
    push_sample(0, 1'b0);
    settle();
    // A zero length behaves as a window of one.
    write_window(CFG_W'(0));
    push_sample(7, 1'b0);
    push_sample(3, 1'b0);
    settle();
    // Tail pops, equal values kept, head expiry, and a restart mid-stream.
    write_window(CFG_W'(4));
    push_sample(16'hFFFF, 1'b1);
    push_sample(16'hFFFF, 1'b0);
    push_sample(16'h5555, 1'b0);
    push_sample(16'hAAAA, 1'b0);
    push_sample(16'hAAAA, 1'b0);
    push_sample(100, 1'b0);
    push_sample(200, 1'b0);
    push_sample(300, 1'b0);
    push_sample(400, 1'b0);
    push_sample(500, 1'b0);
    push_sample(0, 1'b1);

    run_phase(64, 0, 0, 200, 2);
    // Shrinking with a full deque leaves old entries to age out one by one.
    run_phase(2, 85, 0, 150, 2);
    run_phase(65, 0, 85, 150, 2);
    run_phase(1, 38, 38, 150, 2);
    run_phase($urandom_range(3, 63), 0, 0, 200, 2);
    // Hold the result side off so the block backs up into the sample channel.
    stall_arms++;
    run_phase(127, 85, 85, 150, 2);
    run_phase(33, 0, 0, 150, 5);
    // A stretch with no restarts at the full window length.
    run_phase(64, 0, 0, 40, 0);
    run_phase($urandom_range(0, 127), 38, 38, 150, 3);

    settle();
    repeat (70) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule : tb
`default_nettype wire

// ----- files.f -----
design/swm_pkg.sv
design/swm_in_if.sv
design/swm_out_if.sv
design/swm_cfg_if.sv
design/swm_datapath.sv
design/swm_ctrl.sv
design/sliding_window_minimum.sv
sim/tb.sv
